// File: sv/teq_pkg.sv
// ----------------------------------------------------------------------------
// teq_pkg
// Shared types for the serial-line echo queue controller.
// ----------------------------------------------------------------------------
package teq_pkg;

    localparam int BYTE_W = 8;

    typedef enum logic [1:0] {
        OP_HOST_WRITE = 2'd0,
        OP_HOST_READ  = 2'd1,
        OP_RX_BYTE    = 2'd2,
        OP_TX_READY   = 2'd3
    } opcode_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef struct packed {
        logic tx_from_echo;
        logic tx_from_txq;
        logic read_valid;
        logic write_accepted;
        logic rx_dropped;
        logic ready_enable;
    } evt_result_t;

endpackage

// File: sv/teq_byte_fifo.sv
// ----------------------------------------------------------------------------
// teq_byte_fifo
// Byte FIFO on a synchronous memory; pop data is registered and appears in the cycle after the pop.
// ----------------------------------------------------------------------------
module teq_byte_fifo #(
    parameter int DEPTH = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [teq_pkg::BYTE_W-1:0] push_data,
    input  logic                       pop,
    output logic [teq_pkg::BYTE_W-1:0] rd_data,
    output teq_pkg::fifo_stat_t        status
);
    import teq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;
    logic [AW-1:0]     head_reg;
    logic [AW-1:0]     head_next;
    logic [AW-1:0]     tail_reg;
    logic [AW-1:0]     tail_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              push_ok;
    logic              pop_ok;

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign push_ok      = push && !status.full;
    assign pop_ok       = pop && !status.empty;
    assign rd_data      = rd_data_reg;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push_ok)
        begin
            tail_next = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (pop_ok)
        begin
            head_next = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[tail_reg] <= push_data;
        end
        if (pop_ok)
        begin
            rd_data_reg <= mem[head_reg];
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fifo count above depth");

    a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (push && status.full && !pop) |=> $stable(count_reg))
        else $error("push into full fifo changed count");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_ok && !push_ok) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("pop did not decrement count");

endmodule

// File: sv/tty_echo_queue_controller.sv
// ----------------------------------------------------------------------------
// tty_echo_queue_controller
// Serial-line buffer controller with receive, transmit and echo byte queues.
// ----------------------------------------------------------------------------
// One event is taken per cycle as long as results are taken. An accepted
// event first updates queue pointers, issues the memory read and records its
// flags in p1_reg, then forms the result into the output register. The
// synchronous read of each queue memory is why the result is formed in a
// later step than the pointer update. Queue memories have no reset and need
// no clearing pass.
// ----------------------------------------------------------------------------
module tty_echo_queue_controller #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,    // echo_enable
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] data_byte
    input  logic [1:0]  s_tuser,      // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata       // [0] tx_valid, [8:1] tx_byte,
                                      // [9] read_valid, [17:10] read_byte,
                                      // [18] write_accepted, [19] rx_dropped,
                                      // [20] tx_ready_enable, [23:21] zero
);
    import teq_pkg::*;

    opcode_t           op;
    logic              accept;
    logic              advance;
    logic              echo_en_reg;
    logic              ready_en_reg;
    logic              ready_en_next;
    logic              p1_valid_reg;
    evt_result_t       p1_reg;
    evt_result_t       p1_next;
    logic              m_tvalid_reg;
    logic [23:0]       m_tdata_reg;
    logic [23:0]       m_tdata_next;
    logic [BYTE_W-1:0] tx_byte;
    logic [BYTE_W-1:0] read_byte;

    logic              rxq_push, rxq_pop, txq_push, txq_pop, ecq_push, ecq_pop;
    logic [BYTE_W-1:0] rxq_rd, txq_rd, ecq_rd;
    fifo_stat_t        rxq_st, txq_st, ecq_st;

    assign op       = opcode_t'(s_tuser);
    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance || !p1_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        rxq_push      = 1'b0;
        rxq_pop       = 1'b0;
        txq_push      = 1'b0;
        txq_pop       = 1'b0;
        ecq_push      = 1'b0;
        ecq_pop       = 1'b0;
        ready_en_next = ready_en_reg;
        p1_next       = '0;
        unique case (op)
            OP_HOST_WRITE:
            begin
                txq_push               = accept;
                p1_next.write_accepted = !txq_st.full;
                ready_en_next          = 1'b1;
            end
            OP_HOST_READ:
            begin
                rxq_pop            = accept && !rxq_st.empty;
                p1_next.read_valid = !rxq_st.empty;
            end
            OP_RX_BYTE:
            begin
                rxq_push           = accept;
                ecq_push           = accept && !rxq_st.full && echo_en_reg;
                p1_next.rx_dropped = rxq_st.full;
                if (!rxq_st.full && echo_en_reg)
                begin
                    ready_en_next = 1'b1;
                end
            end
            OP_TX_READY:
            begin
                ecq_pop              = accept && !ecq_st.empty;
                txq_pop              = accept && ecq_st.empty && !txq_st.empty;
                p1_next.tx_from_echo = !ecq_st.empty;
                p1_next.tx_from_txq  = ecq_st.empty && !txq_st.empty;
                if (ecq_st.empty && txq_st.empty)
                begin
                    ready_en_next = 1'b0;
                end
            end
            default:
            begin
                ready_en_next = ready_en_reg;
            end
        endcase
        p1_next.ready_enable = ready_en_next;
    end

    teq_byte_fifo #(.DEPTH(QUEUE_DEPTH)) u_rxq (
        .clk(clk), .rst_n(rst_n), .push(rxq_push), .push_data(s_tdata),
        .pop(rxq_pop), .rd_data(rxq_rd), .status(rxq_st)
    );

    teq_byte_fifo #(.DEPTH(QUEUE_DEPTH)) u_txq (
        .clk(clk), .rst_n(rst_n), .push(txq_push), .push_data(s_tdata),
        .pop(txq_pop), .rd_data(txq_rd), .status(txq_st)
    );

    teq_byte_fifo #(.DEPTH(QUEUE_DEPTH)) u_ecq (
        .clk(clk), .rst_n(rst_n), .push(ecq_push), .push_data(s_tdata),
        .pop(ecq_pop), .rd_data(ecq_rd), .status(ecq_st)
    );

    always_comb
    begin
        if (p1_reg.tx_from_echo)
        begin
            tx_byte = ecq_rd;
        end
        else if (p1_reg.tx_from_txq)
        begin
            tx_byte = txq_rd;
        end
        else
        begin
            tx_byte = '0;
        end
        read_byte    = p1_reg.read_valid ? rxq_rd : '0;
        m_tdata_next = {3'b000,
                        p1_reg.ready_enable,
                        p1_reg.rx_dropped,
                        p1_reg.write_accepted,
                        read_byte,
                        p1_reg.read_valid,
                        tx_byte,
                        p1_reg.tx_from_echo | p1_reg.tx_from_txq};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            echo_en_reg  <= 1'b1;
            ready_en_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                echo_en_reg <= cfg_wdata;
            end
            if (accept)
            begin
                ready_en_reg <= ready_en_next;
            end
            if (accept)
            begin
                p1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                p1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                m_tvalid_reg <= p1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_reg <= p1_next;
        end
        if (advance && p1_valid_reg)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    a_tx_source: assert property (@(posedge clk) disable iff (!rst_n)
        p1_valid_reg |-> !(p1_reg.tx_from_echo && p1_reg.tx_from_txq))
        else $error("transmit byte taken from two queues");

    a_echo_first: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_TX_READY && !ecq_st.empty) |-> !txq_pop)
        else $error("transmit queue popped ahead of echo queue");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (p1_valid_reg && m_tvalid_reg && !m_tready) |-> !s_tready)
        else $error("event taken while pipeline is blocked");

    a_enable_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_TX_READY && ecq_st.empty && txq_st.empty)
        |=> !ready_en_reg)
        else $error("enable not cleared with both queues empty");

endmodule
